FILE: rtl/dfp_pkg.sv
package dfp_pkg;

  localparam int unsigned FracDigitsKept = 9;
  localparam int unsigned MaxStringBytes = 256;
  localparam int unsigned CfgW = 9;
  localparam logic [CfgW-1:0] MaxStringLenReset = 9'd32;

  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChNul = 8'h00;

  typedef enum logic [1:0] {
    KindInt  = 2'd0,
    KindUint = 2'd1,
    KindDec  = 2'd2,
    KindStr  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadChar = 2'd1,
    StEmpty   = 2'd2,
    StTooLong = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PhIdle,
    PhWhole,
    PhFrac,
    PhString,
    PhSkip
  } phase_e;

  typedef enum logic [1:0] {
    OpChar,
    OpDone,
    OpDec
  } op_e;

  // One queued command from the front end to the back end.
  typedef struct packed {
    op_e         op;
    logic [7:0]  ch;
    logic [47:0] value;
    logic [1:0]  status;
    logic        negative;
    logic [31:0] whole;
    logic [29:0] frac;
    logic [3:0]  digits;
  } cmd_t;

  typedef struct packed {
    logic        is_char;
    logic [7:0]  char_out;
    logic [47:0] value;
    logic [1:0]  status;
    logic        last;
  } res_t;

  function automatic logic [29:0] pow10(input logic [3:0] d);
    logic [29:0] p;
    p = 30'd1;
    unique case (d)
      4'd0: p = 30'd1;
      4'd1: p = 30'd10;
      4'd2: p = 30'd100;
      4'd3: p = 30'd1000;
      4'd4: p = 30'd10000;
      4'd5: p = 30'd100000;
      4'd6: p = 30'd1000000;
      4'd7: p = 30'd10000000;
      4'd8: p = 30'd100000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/dfp_front.sv
module dfp_front #(
  parameter int unsigned MaxBytes = dfp_pkg::MaxStringBytes,
  parameter int unsigned FracKept = dfp_pkg::FracDigitsKept
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          byte_i,
  input  logic [1:0]          kind_i,
  input  logic [8:0]          max_len_i,
  output logic                cmd_valid_o,
  output dfp_pkg::cmd_t       cmd_o,
  input  logic                cmd_room_i
);
  import dfp_pkg::*;

  localparam int unsigned CntW = $clog2(MaxBytes + 1);
  localparam logic [3:0] KeptLim = (FracKept < 9) ? 4'(FracKept) : 4'd9;

  phase_e      phase_q, phase_d;
  kind_e       kind_q, kind_d;
  logic        neg_q, neg_d;
  logic [31:0] whole_q, whole_d;
  logic [29:0] frac_q, frac_d;
  logic [3:0]  digits_q, digits_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic        bs_q, bs_d;
  logic [1:0]  err_q, err_d;

  logic [CntW-1:0] limit;
  logic        emit;
  cmd_t        cmd;
  logic        fire;
  logic        bs_flush;
  logic        is_dig;
  logic [3:0]  dig;

  always_comb begin
    if (max_len_i < 9'd2) limit = CntW'(2);
    else if (32'(max_len_i) > MaxBytes) limit = CntW'(MaxBytes);
    else limit = CntW'(max_len_i);
  end

  // A lone backslash goes out before the byte behind it is taken.
  assign bs_flush = in_valid_i && phase_q == PhString && bs_q && byte_i != ChSemi;
  assign in_ready_o = cmd_room_i && !bs_flush;
  assign fire = in_valid_i && in_ready_o;
  assign is_dig = byte_i >= ChZero && byte_i <= ChNine;
  assign dig = 4'(byte_i - ChZero);

  always_comb begin
    phase_d = phase_q; kind_d = kind_q; neg_d = neg_q; whole_d = whole_q;
    frac_d = frac_q; digits_d = digits_q; cnt_d = cnt_q; bs_d = bs_q;
    err_d = err_q;
    emit = 1'b0;
    cmd = '0;
    cmd.op = OpDone;
    cmd.negative = neg_q;
    cmd.whole = whole_q;
    cmd.frac = frac_q;
    cmd.digits = digits_q;
    if (bs_flush && cmd_room_i) begin
      bs_d = 1'b0;
      if (cnt_q + 1'b1 >= limit) begin
        err_d = StTooLong; phase_d = PhSkip;
      end else begin
        emit = 1'b1; cmd.op = OpChar; cmd.ch = ChBackslash; cnt_d = cnt_q + 1'b1;
      end
    end else if (fire) begin
      unique case (phase_q)
        PhIdle: begin
          if (byte_i != ChNul) begin
            kind_d = kind_e'(kind_i); neg_d = 1'b0; whole_d = '0; frac_d = '0;
            digits_d = '0; cnt_d = '0; bs_d = 1'b0; err_d = StOk;
            if (kind_e'(kind_i) == KindStr) begin
              if (byte_i == ChSemi) begin
                emit = 1'b1; cmd.status = StEmpty;
              end else if (byte_i == ChBackslash) begin
                bs_d = 1'b1; phase_d = PhString;
              end else if (limit <= CntW'(1)) begin
                phase_d = PhString;
              end else begin
                phase_d = PhString; emit = 1'b1; cmd.op = OpChar;
                cmd.ch = byte_i; cnt_d = CntW'(1);
              end
            end else begin
              phase_d = PhWhole;
              cmd.negative = 1'b0; cmd.whole = '0; cmd.digits = '0; cmd.frac = '0;
              if (byte_i == ChMinus && kind_e'(kind_i) != KindUint) begin
                neg_d = 1'b1;
              end else if (is_dig) begin
                whole_d = 32'(dig);
              end else if (byte_i == ChSemi) begin
                emit = 1'b1; phase_d = PhIdle;
                cmd.op = (kind_e'(kind_i) == KindDec) ? OpDec : OpDone;
              end else if (byte_i == ChPoint && kind_e'(kind_i) == KindDec) begin
                phase_d = PhFrac;
              end else begin
                err_d = StBadChar; phase_d = PhSkip;
              end
            end
          end
        end
        PhWhole: begin
          if (is_dig) begin
            whole_d = {whole_q[28:0], 3'b0} + {whole_q[30:0], 1'b0} + 32'(dig);
          end else if (byte_i == ChSemi) begin
            emit = 1'b1; phase_d = PhIdle;
            if (kind_q == KindDec) cmd.op = OpDec;
            else if (kind_q == KindUint) cmd.value = {16'd0, whole_q};
            else begin
              cmd.value = 48'(signed'(neg_q ? (32'd0 - whole_q) : whole_q));
            end
          end else if (byte_i == ChPoint && kind_q == KindDec) begin
            phase_d = PhFrac;
          end else if (byte_i == ChNul) begin
            emit = 1'b1; cmd.status = StBadChar; phase_d = PhIdle;
          end else begin
            err_d = StBadChar; phase_d = PhSkip;
          end
        end
        PhFrac: begin
          if (is_dig) begin
            if (digits_q < KeptLim) begin
              frac_d = {frac_q[26:0], 3'b0} + {frac_q[28:0], 1'b0} + 30'(dig);
              digits_d = digits_q + 1'b1;
            end
          end else if (byte_i == ChSemi) begin
            emit = 1'b1; cmd.op = OpDec; phase_d = PhIdle;
          end else if (byte_i == ChNul) begin
            emit = 1'b1; cmd.status = StBadChar; phase_d = PhIdle;
          end else begin
            err_d = StBadChar; phase_d = PhSkip;
          end
        end
        PhString: begin
          if (bs_q) begin
            bs_d = 1'b0;
            if (cnt_q + 1'b1 >= limit) begin
              err_d = StTooLong; phase_d = PhSkip;
            end else begin
              emit = 1'b1; cmd.op = OpChar; cmd.ch = ChSemi; cnt_d = cnt_q + 1'b1;
            end
          end else if (byte_i == ChNul || byte_i == ChSemi) begin
            emit = 1'b1; phase_d = PhIdle;
          end else if (byte_i == ChBackslash) begin
            bs_d = 1'b1;
          end else if (cnt_q + 1'b1 >= limit) begin
            err_d = StTooLong; phase_d = PhSkip;
          end else begin
            emit = 1'b1; cmd.op = OpChar; cmd.ch = byte_i; cnt_d = cnt_q + 1'b1;
          end
        end
        default: begin
          if (byte_i == ChNul || byte_i == ChSemi) begin
            emit = 1'b1; cmd.status = err_q; phase_d = PhIdle;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle; kind_q <= KindInt; neg_q <= 1'b0; whole_q <= '0;
      frac_q <= '0; digits_q <= '0; cnt_q <= '0; bs_q <= 1'b0; err_q <= StOk;
    end else begin
      phase_q <= phase_d; kind_q <= kind_d; neg_q <= neg_d; whole_q <= whole_d;
      frac_q <= frac_d; digits_q <= digits_d; cnt_q <= cnt_d; bs_q <= bs_d;
      err_q <= err_d;
    end
  end

  assign cmd_valid_o = emit;
  assign cmd_o = cmd;
endmodule

FILE: rtl/dfp_queue.sv
module dfp_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  dfp_pkg::cmd_t wdata_i,
  output logic          room_o,
  output logic          valid_o,
  output dfp_pkg::cmd_t rdata_o,
  input  logic          rd_i
);
  import dfp_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t            mem_q [Depth];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;

  // Room for two so a consumed byte never overflows the queue.
  assign room_o = 32'(cnt_q) + 2 <= Depth;
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= (32'(wp_q) == Depth - 1) ? '0 : wp_q + 1'b1;
      if (rd_i) rp_q <= (32'(rp_q) == Depth - 1) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr_i) - (AW+1)'(rd_i);
    end
  end
endmodule

FILE: rtl/dfp_back.sv
module dfp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  dfp_pkg::cmd_t cmd_i,
  output logic          cmd_take_o,
  output logic          res_valid_o,
  output dfp_pkg::res_t res_o,
  input  logic          res_ready_i
);
  import dfp_pkg::*;

  // The fraction is scaled to nine digits, so (frac << 16) / 10^d becomes
  // (f << 7) / 5^9, found by a reciprocal multiply and one correction step.
  localparam logic [31:0] Recip = 32'd2305843009;
  localparam logic [20:0] Pow5Nine = 21'd1953125;

  logic          busy_q, busy_d;
  logic [1:0]    step_q, step_d;
  logic          neg_q;
  logic [47:0]   ip_q;
  logic [29:0]   frac_q;
  logic [29:0]   scale_q;
  logic [29:0]   f_q;
  logic [15:0]   qe_q;
  logic          out_v_q, out_v_d;
  res_t          out_q;
  logic [31:0]   whole_s;
  logic [29:0]   f_mul;
  logic [61:0]   p_mul;
  logic [36:0]   q_back;
  logic [36:0]   rem;
  logic [15:0]   quot;
  logic [47:0]   fq, dec_val;
  logic          out_free;
  logic          divide;
  logic          done;

  assign out_free = !out_v_q || res_ready_i;
  assign cmd_take_o = cmd_valid_i && !busy_q && out_free;
  assign divide = cmd_i.op == OpDec && cmd_i.digits != 4'd0;
  assign done = busy_q && step_q == 2'd2 && out_free;
  assign whole_s = cmd_i.negative ? 32'd0 - cmd_i.whole : cmd_i.whole;
  assign f_mul = frac_q * scale_q;
  assign p_mul = 62'(f_q) * 62'(Recip);
  assign q_back = 37'(qe_q) * 37'(Pow5Nine);
  assign rem = {f_q, 7'd0} - q_back;
  assign quot = qe_q + 16'(rem >= 37'(Pow5Nine));
  assign fq = {32'd0, quot};
  assign dec_val = neg_q ? ip_q - fq : ip_q + fq;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    out_v_d = out_v_q;
    if (out_v_q && res_ready_i) out_v_d = 1'b0;
    if (cmd_take_o) begin
      if (divide) begin
        busy_d = 1'b1;
        step_d = 2'd0;
      end else begin
        out_v_d = 1'b1;
      end
    end else if (busy_q) begin
      if (done) begin
        busy_d = 1'b0;
        out_v_d = 1'b1;
      end else if (step_q != 2'd2) begin
        step_d = step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; out_v_q <= 1'b0; step_q <= '0;
    end else begin
      busy_q <= busy_d; out_v_q <= out_v_d; step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      neg_q <= cmd_i.negative;
      ip_q <= {whole_s, 16'd0};
      frac_q <= cmd_i.frac;
      scale_q <= pow10(4'd9 - ((cmd_i.digits > 4'd9) ? 4'd9 : cmd_i.digits));
      out_q.is_char <= cmd_i.op == OpChar;
      out_q.char_out <= cmd_i.ch;
      out_q.status <= cmd_i.status;
      out_q.last <= cmd_i.op != OpChar;
      out_q.value <= (cmd_i.op == OpDec) ? {whole_s, 16'd0} : cmd_i.value;
    end else if (busy_q) begin
      if (step_q == 2'd0) f_q <= f_mul;
      if (step_q == 2'd1) qe_q <= p_mul[60:45];
      if (done) out_q.value <= dec_val;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o = out_q;
endmodule

FILE: rtl/delimited_field_parser_top.sv
// Channel   | Direction | Payload
// s_axis    | in        | tdata[7:0] text_byte, tuser[1:0] kind
// m_axis    | out       | tdata[57:0] char_out,value,status (+pad), tuser is_char, tlast
// cfg       | in        | cfg_data_i[8:0] max_string_len
// A byte is taken while the command queue has room for two words and no lone backslash is going out.
// The byte after a lone backslash waits while the backslash goes out.
// A decimal field with fraction digits keeps the back end busy through its scale, multiply and correction steps.
// Reset clears all control state; max_string_len returns to 32.
// Either side may stall; the queue between front and back absorbs short stalls.
module delimited_field_parser_top #(
  parameter int unsigned MaxBytes = dfp_pkg::MaxStringBytes,
  parameter int unsigned FracKept = dfp_pkg::FracDigitsKept
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_byte
  input  logic [1:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // char_out[7:0], value[55:8], status[57:56]
  output logic        m_axis_tuser,   // is_char
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i
);
  import dfp_pkg::*;

  logic [8:0] max_len_q;
  logic       cmd_v, room, q_v, take;
  cmd_t       cmd, q_cmd;
  res_t       res;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_len_q <= MaxStringLenReset;
    else if (cfg_valid_i) max_len_q <= cfg_data_i;
  end

  dfp_front #(.MaxBytes(MaxBytes), .FracKept(FracKept)) u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .byte_i(s_axis_tdata), .kind_i(s_axis_tuser), .max_len_i(max_len_q),
    .cmd_valid_o(cmd_v), .cmd_o(cmd), .cmd_room_i(room)
  );

  dfp_queue #(.Depth(4)) u_queue (
    .clk_i, .rst_ni, .wr_i(cmd_v), .wdata_i(cmd), .room_o(room),
    .valid_o(q_v), .rdata_o(q_cmd), .rd_i(take)
  );

  dfp_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_v), .cmd_i(q_cmd), .cmd_take_o(take),
    .res_valid_o(m_axis_tvalid), .res_o(res), .res_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {6'd0, res.status, res.value, res.char_out};
  assign m_axis_tuser = res.is_char;
  assign m_axis_tlast = res.last;
endmodule
